// ===== hw/rtl/aes_pkg.sv =====
// AES-128 package: payload and control structs, state enum, S-box and GF helpers.
// Used by all modules under hw/rtl; depends on nothing.
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundW    = 4;

  // configuration register indexes
  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow  = 2'd1;
  localparam logic [1:0] RegMode    = 2'd2;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  typedef enum logic [1:0] {
    StIdle,
    StExpand,
    StRun
  } aes_state_e;

  // controller -> datapath
  typedef struct packed {
    logic              load;       // capture block, do initial key add
    logic              round;      // run one round
    logic              last;       // final round (no mix)
    logic              decrypt;
    logic [RoundW-1:0] rk_idx;     // round key used this cycle
    logic              kx_start;   // begin key expansion
    logic              kx_step;    // one round key generated
  } aes_ctrl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    gmul = (b[0] ? a : 8'h00) ^ (b[1] ? a2 : 8'h00) ^
           (b[2] ? a4 : 8'h00) ^ (b[3] ? a8 : 8'h00);
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RSBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

endpackage

// ===== hw/rtl/aes_ctrl.sv =====
// AES controller: sequences key expansion and the ten cipher rounds.
// Depends on aes_pkg.
module aes_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 key_wr_i,
  input  logic                 decrypt_i,
  output logic                 busy_o,
  output logic                 done_o,
  output aes_pkg::aes_ctrl_t   ctrl_o
);

  aes_pkg::aes_state_e state_q, state_d;
  logic [aes_pkg::RoundW-1:0] cnt_q, cnt_d;
  logic dec_q, dec_d;
  logic done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aes_pkg::StIdle;
      cnt_q   <= '0;
      dec_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dec_q   <= dec_d;
      done_q  <= done_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dec_d   = dec_q;
    done_d  = 1'b0;
    ctrl_o  = '0;
    ctrl_o.decrypt = dec_q;
    unique case (state_q)
      aes_pkg::StIdle: begin
        if (key_wr_i) begin
          ctrl_o.kx_start = 1'b1;
          cnt_d   = aes_pkg::RoundW'(1);
          state_d = aes_pkg::StExpand;
        end else if (start_i) begin
          ctrl_o.load    = 1'b1;
          ctrl_o.decrypt = decrypt_i;
          ctrl_o.rk_idx  = decrypt_i ? aes_pkg::RoundW'(aes_pkg::NumRounds) : '0;
          dec_d   = decrypt_i;
          cnt_d   = aes_pkg::RoundW'(1);
          state_d = aes_pkg::StRun;
        end
      end
      aes_pkg::StExpand: begin
        ctrl_o.kx_step = 1'b1;
        ctrl_o.rk_idx  = cnt_q;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == aes_pkg::RoundW'(aes_pkg::NumRounds)) state_d = aes_pkg::StIdle;
      end
      aes_pkg::StRun: begin
        ctrl_o.round  = 1'b1;
        ctrl_o.last   = (cnt_q == aes_pkg::RoundW'(aes_pkg::NumRounds));
        ctrl_o.rk_idx = dec_q ? aes_pkg::RoundW'(aes_pkg::NumRounds) - cnt_q : cnt_q;
        cnt_d = cnt_q + 1'b1;
        if (ctrl_o.last) begin
          done_d  = 1'b1;
          state_d = aes_pkg::StIdle;
        end
      end
      default: state_d = aes_pkg::StIdle;
    endcase
  end

  assign busy_o = (state_q != aes_pkg::StIdle) || key_wr_i;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/aes_dp.sv =====
// AES datapath: key schedule registers, shared round unit, result register.
// Depends on aes_pkg.
module aes_dp (
  input  logic               clk_i,
  input  logic [127:0]       key_i,
  input  aes_pkg::aes_in_t   in_i,
  input  aes_pkg::aes_ctrl_t ctrl_i,
  output aes_pkg::aes_out_t  out_o
);

  // round keys, one 128-bit row per round (columns 0..3, row-0 byte high)
  logic [127:0] rk_q [aes_pkg::NumRounds+1];
  logic [127:0] st_q, st_d;
  logic [7:0]   rcon_q;

  // byte in row-major state order
  function automatic logic [7:0] sb(input logic [127:0] s, input int unsigned i);
    sb = s[127-8*i -: 8];
  endfunction

  // key word c byte r maps to state byte r*4+c
  function automatic logic [127:0] key_to_state(input logic [127:0] k);
    logic [127:0] s;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        s[127-8*(r*4+c) -: 8] = k[127-32*c-8*r -: 8];
    key_to_state = s;
  endfunction

  function automatic logic [127:0] state_to_key(input logic [127:0] s);
    logic [127:0] k;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        k[127-32*c-8*r -: 8] = s[127-8*(r*4+c) -: 8];
    state_to_key = k;
  endfunction

  // next round key from previous one
  logic [127:0] prev_rk, next_rk;
  logic [31:0]  t_w;
  always_comb begin
    prev_rk = rk_q[ctrl_i.rk_idx - 1'b1];
    t_w = {aes_pkg::SBOX[prev_rk[23:16]] ^ rcon_q, aes_pkg::SBOX[prev_rk[15:8]],
           aes_pkg::SBOX[prev_rk[7:0]], aes_pkg::SBOX[prev_rk[31:24]]};
    next_rk[127:96] = prev_rk[127:96] ^ t_w;
    next_rk[95:64]  = prev_rk[95:64] ^ next_rk[127:96];
    next_rk[63:32]  = prev_rk[63:32] ^ next_rk[95:64];
    next_rk[31:0]   = prev_rk[31:0]  ^ next_rk[63:32];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.kx_start) begin
      rk_q[0] <= state_to_key(key_i);
      rcon_q  <= 8'h01;
    end else if (ctrl_i.kx_step) begin
      rk_q[ctrl_i.rk_idx] <= next_rk;
      rcon_q <= aes_pkg::xtime(rcon_q);
    end
  end

  // round unit
  logic [127:0] rks, sub_s, sh_s, mix_s, rk_mix, ark;
  logic [7:0]   m0, m1, m2, m3;
  always_comb begin
    rks = key_to_state(rk_q[ctrl_i.rk_idx]);
    for (int i = 0; i < 16; i++) begin
      // shift first (sub is bytewise, order commutes)
      sh_s[127-8*i -: 8] = ctrl_i.decrypt ?
        sb(st_q, (i/4)*4 + ((i%4 - i/4) & 3)) : sb(st_q, (i/4)*4 + ((i%4 + i/4) & 3));
    end
    for (int i = 0; i < 16; i++)
      sub_s[127-8*i -: 8] = ctrl_i.decrypt ? aes_pkg::RSBOX[sb(sh_s, i)]
                                           : aes_pkg::SBOX[sb(sh_s, i)];
    // decrypt adds the round key before the inverse mix: inverse cipher order (mix(x)^mix(k) = mix(x^k))
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        m0 = ctrl_i.decrypt ? 8'd14 : 8'd2;
        m1 = ctrl_i.decrypt ? 8'd11 : 8'd3;
        m2 = ctrl_i.decrypt ? 8'd13 : 8'd1;
        m3 = ctrl_i.decrypt ? 8'd9  : 8'd1;
        mix_s[127-8*(r*4+c) -: 8] =
          aes_pkg::gmul(sb(ctrl_i.decrypt ? (sub_s ^ rks) : sub_s, ((r+0)&3)*4+c), m0[3:0]) ^
          aes_pkg::gmul(sb(ctrl_i.decrypt ? (sub_s ^ rks) : sub_s, ((r+1)&3)*4+c), m1[3:0]) ^
          aes_pkg::gmul(sb(ctrl_i.decrypt ? (sub_s ^ rks) : sub_s, ((r+2)&3)*4+c), m2[3:0]) ^
          aes_pkg::gmul(sb(ctrl_i.decrypt ? (sub_s ^ rks) : sub_s, ((r+3)&3)*4+c), m3[3:0]);
      end
    rk_mix = ctrl_i.decrypt ? '0 : rks;
    ark = ctrl_i.last ? (sub_s ^ rks) : (mix_s ^ rk_mix);
    st_d = ctrl_i.load ? ({in_i.block_high, in_i.block_low} ^ rks) : ark;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load || ctrl_i.round) st_q <= st_d;
  end

  assign out_o = aes_pkg::aes_out_t'(st_q);

endmodule

// ===== hw/rtl/aes128_block_cipher_unit.sv =====
// AES-128 top level: config registers, controller and datapath.
// Depends on aes_pkg, aes_ctrl, aes_dp.
// A block runs the initial key add plus ten rounds of one shared round unit;
// no new block starts while one is running. A key write triggers a key
// expansion, during which busy is high; cfg_ready_o is low while a block or an
// expansion runs. Reset (rst_ni, async low) clears control and config; the
// receiver cannot stall, done_o pulses for one cycle.
module aes128_block_cipher_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  aes_pkg::aes_in_t  data_i,
  output logic              done_o,
  output aes_pkg::aes_out_t data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [63:0]       cfg_wdata_i
);

  logic [63:0] key_high_q, key_low_q;
  logic        mode_q;
  logic        cfg_wr, key_wr;
  aes_pkg::aes_ctrl_t ctrl;
  logic        ctrl_busy;

  // writes only while no block or expansion is running
  assign cfg_ready_o = !ctrl_busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign key_wr      = cfg_wr && ((cfg_index_i == aes_pkg::RegKeyHigh) ||
                                  (cfg_index_i == aes_pkg::RegKeyLow));

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      mode_q     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        aes_pkg::RegKeyHigh: key_high_q <= cfg_wdata_i;
        aes_pkg::RegKeyLow:  key_low_q  <= cfg_wdata_i;
        aes_pkg::RegMode:    mode_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // expansion starts the cycle after the write, from the updated registers
  logic kx_pend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) kx_pend_q <= 1'b0;
    else         kx_pend_q <= key_wr;
  end

  aes_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start && !busy),
    .key_wr_i  (kx_pend_q),
    .decrypt_i (mode_q),
    .busy_o    (ctrl_busy),
    .done_o    (done_o),
    .ctrl_o    (ctrl)
  );

  // a config write and a block start never share an edge
  assign busy = ctrl_busy || cfg_wr;

  aes_dp u_dp (
    .clk_i  (clk_i),
    .key_i  ({key_high_q, key_low_q}),
    .in_i   (data_i),
    .ctrl_i (ctrl),
    .out_o  (data_o)
  );

endmodule
